[rtl/shaping_snapshot_parser_unit_macros.svh]
// Assertion macros for the shaping snapshot parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SHAPING_SNAPSHOT_PARSER_UNIT_MACROS_SVH
`define SHAPING_SNAPSHOT_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SSP_ASSERT(lbl, clk, rstn, prop, msg)
`define SSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[rtl/ssp_pkg.sv]
// Types, codes and constants of the shaping snapshot parser.
// Used by ssp_in_reg, ssp_core, ssp_out_reg and the top level; depends on nothing.
package ssp_pkg;

  localparam int unsigned MaxPointsDef = 256;

  localparam logic [7:0]  TypeByte    = 8'd3;
  localparam logic [7:0]  VersionByte = 8'd1;
  localparam logic [19:0] ProbOne     = 20'd1000000;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindId    = 2'd1;
  localparam logic [1:0] KindCount = 2'd2;
  localparam logic [1:0] KindPoint = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StVersion = 2'd2;

  typedef enum logic [3:0] {
    PhType,
    PhVersion,
    PhIdLen,
    PhIdBytes,
    PhRecCount,
    PhTabCount,
    PhBound,
    PhProb,
    PhTrail,
    PhSink
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic        direction_slot;
    logic        table_select;
    logic [63:0] field_value;
    logic [19:0] point_probability;
    logic [7:0]  point_number;
    logic        final_point;
    logic        message_done;
    logic [1:0]  parse_status;
  } result_t;

endpackage

[rtl/ssp_stream_if.sv]
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from ssp_pkg at the instance.
interface ssp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/ssp_in_reg.sv]
// Input register of the parser: captures one message byte per accepted word.
// Depends on ssp_pkg and ssp_stream_if.
module ssp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssp_stream_if.sink        in_i,
  input  logic              adv_i,
  output ssp_pkg::in_word_t word_o,
  output logic              vld_o
);

  logic              vld_q;
  ssp_pkg::in_word_t word_q;

  assign in_i.ready = !vld_q || adv_i;
  assign word_o     = word_q;
  assign vld_o      = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q <= in_i.payload;
    end
  end

endmodule

[rtl/ssp_core.sv]
// Parse state and single-pass byte logic of the shaping snapshot parser.
// Depends on ssp_pkg and the assertion macros header.
`include "shaping_snapshot_parser_unit_macros.svh"

module ssp_core #(
  parameter int unsigned MaxPoints = ssp_pkg::MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssp_pkg::in_word_t word_i,
  input  logic              adv_i,
  output ssp_pkg::result_t  res_o,
  output logic              res_vld_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  ssp_pkg::phase_e phase_q, phase_d;
  logic [2:0]      nbytes_q, nbytes_d;
  logic [63:0]     shift_q, shift_d;
  logic [7:0]      id_left_q, id_left_d;
  logic            dir_q, dir_d;
  logic            tab_q, tab_d;
  logic [CntW-1:0] pcount_q, pcount_d;
  logic [CntW-1:0] pseen_q, pseen_d;
  logic [31:0]     held_q, held_d;
  logic [31:0]     pbound_q, pbound_d;
  logic [19:0]     pprob_q, pprob_d;
  logic            err_q, err_d;
  logic            vbad_q, vbad_d;

  logic [7:0]      b;
  logic [63:0]     shifted;
  logic [15:0]     cnt;
  logic [31:0]     raw;
  logic            last;
  logic            raw_big;
  logic [19:0]     prob;
  logic [15:0]     seen16;
  ssp_pkg::result_t res;

  assign b       = word_i.data_byte;
  assign shifted = {shift_q[55:0], b};
  assign cnt     = shifted[15:0];
  assign raw     = shifted[31:0];
  assign last    = (17'(pseen_q) + 17'd1) >= 17'(pcount_q);
  assign raw_big = raw > 32'(ssp_pkg::ProbOne);
  assign prob    = (last || raw_big) ? ssp_pkg::ProbOne : raw[19:0];
  assign seen16  = 16'(pseen_q);

  always_comb begin
    phase_d   = phase_q;
    nbytes_d  = nbytes_q;
    shift_d   = shift_q;
    id_left_d = id_left_q;
    dir_d     = dir_q;
    tab_d     = tab_q;
    pcount_d  = pcount_q;
    pseen_d   = pseen_q;
    held_d    = held_q;
    pbound_d  = pbound_q;
    pprob_d   = pprob_q;
    err_d     = err_q;
    vbad_d    = vbad_q;
    res       = '0;

    case (phase_q)
      ssp_pkg::PhType: begin
        if (b != ssp_pkg::TypeByte) err_d = 1'b1;
        phase_d = ssp_pkg::PhVersion;
      end
      ssp_pkg::PhVersion: begin
        if (b != ssp_pkg::VersionByte && !err_q) vbad_d = 1'b1;
        phase_d = ssp_pkg::PhIdLen;
      end
      ssp_pkg::PhIdLen: begin
        id_left_d = b;
        shift_d   = '0;
        nbytes_d  = '0;
        phase_d   = (b == 8'd0) ? ssp_pkg::PhRecCount : ssp_pkg::PhIdBytes;
      end
      ssp_pkg::PhIdBytes: begin
        res.item_kind   = ssp_pkg::KindId;
        res.field_value = 64'(b);
        id_left_d       = id_left_q - 8'd1;
        if (id_left_q == 8'd1) phase_d = ssp_pkg::PhRecCount;
      end
      ssp_pkg::PhRecCount: begin
        shift_d  = shifted;
        nbytes_d = nbytes_q + 3'd1;
        if (nbytes_q == 3'd7) begin
          nbytes_d           = '0;
          shift_d            = '0;
          res.item_kind      = ssp_pkg::KindCount;
          res.direction_slot = dir_q;
          res.field_value    = shifted;
          tab_d              = 1'b0;
          phase_d            = ssp_pkg::PhTabCount;
        end
      end
      ssp_pkg::PhTabCount: begin
        shift_d  = shifted;
        nbytes_d = nbytes_q + 3'd1;
        if (nbytes_q == 3'd1) begin
          nbytes_d = '0;
          shift_d  = '0;
          if (cnt == 16'd0 || 17'(cnt) > 17'(MaxPoints)) begin
            err_d   = 1'b1;
            phase_d = ssp_pkg::PhSink;
          end else begin
            pcount_d = cnt[CntW-1:0];
            pseen_d  = '0;
            pbound_d = '0;
            pprob_d  = '0;
            phase_d  = ssp_pkg::PhBound;
          end
        end
      end
      ssp_pkg::PhBound: begin
        shift_d  = shifted;
        nbytes_d = nbytes_q + 3'd1;
        if (nbytes_q == 3'd3) begin
          nbytes_d = '0;
          shift_d  = '0;
          held_d   = raw;
          phase_d  = ssp_pkg::PhProb;
        end
      end
      ssp_pkg::PhProb: begin
        shift_d  = shifted;
        nbytes_d = nbytes_q + 3'd1;
        if (nbytes_q == 3'd3) begin
          nbytes_d = '0;
          shift_d  = '0;
          if (held_q == 32'd0 || raw_big) err_d = 1'b1;
          if (pseen_q != '0 && held_q < pbound_q) err_d = 1'b1;
          if (prob <= pprob_q) err_d = 1'b1;
          res.item_kind         = ssp_pkg::KindPoint;
          res.direction_slot    = dir_q;
          res.table_select      = tab_q;
          res.field_value       = 64'(held_q);
          res.point_probability = prob;
          res.point_number      = seen16[7:0];
          res.final_point       = last;
          pbound_d = held_q;
          pprob_d  = prob;
          pseen_d  = pseen_q + CntW'(1);
          if (!last) begin
            phase_d = ssp_pkg::PhBound;
          end else if (!tab_q) begin
            tab_d   = 1'b1;
            phase_d = ssp_pkg::PhTabCount;
          end else if (!dir_q) begin
            dir_d   = 1'b1;
            tab_d   = 1'b0;
            phase_d = ssp_pkg::PhRecCount;
          end else begin
            phase_d = ssp_pkg::PhTrail;
          end
        end
      end
      ssp_pkg::PhTrail: begin
        err_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (word_i.end_of_message) begin
      res.message_done = 1'b1;
      if (phase_q == ssp_pkg::PhType || phase_q == ssp_pkg::PhVersion) begin
        res.parse_status = ssp_pkg::StInvalid;
      end else if (vbad_d) begin
        res.parse_status = ssp_pkg::StVersion;
      end else if (err_d || phase_d != ssp_pkg::PhTrail) begin
        res.parse_status = ssp_pkg::StInvalid;
      end else begin
        res.parse_status = ssp_pkg::StOk;
      end
    end
  end

  assign res_o     = res;
  assign res_vld_o = adv_i && (word_i.end_of_message || res.item_kind != ssp_pkg::KindNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ssp_pkg::PhType;
      nbytes_q  <= '0;
      shift_q   <= '0;
      id_left_q <= '0;
      dir_q     <= 1'b0;
      tab_q     <= 1'b0;
      pcount_q  <= '0;
      pseen_q   <= '0;
      held_q    <= '0;
      pbound_q  <= '0;
      pprob_q   <= '0;
      err_q     <= 1'b0;
      vbad_q    <= 1'b0;
    end else if (adv_i) begin
      if (word_i.end_of_message) begin
        phase_q   <= ssp_pkg::PhType;
        nbytes_q  <= '0;
        shift_q   <= '0;
        id_left_q <= '0;
        dir_q     <= 1'b0;
        tab_q     <= 1'b0;
        pcount_q  <= '0;
        pseen_q   <= '0;
        held_q    <= '0;
        pbound_q  <= '0;
        pprob_q   <= '0;
        err_q     <= 1'b0;
        vbad_q    <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        nbytes_q  <= nbytes_d;
        shift_q   <= shift_d;
        id_left_q <= id_left_d;
        dir_q     <= dir_d;
        tab_q     <= tab_d;
        pcount_q  <= pcount_d;
        pseen_q   <= pseen_d;
        held_q    <= held_d;
        pbound_q  <= pbound_d;
        pprob_q   <= pprob_d;
        err_q     <= err_d;
        vbad_q    <= vbad_d;
      end
    end
  end

  `SSP_ASSERT(a_done_clears, clk_i, rst_ni, adv_i && word_i.end_of_message |=> phase_q == ssp_pkg::PhType && !err_q && !vbad_q, "State not cleared after the final word.")
  `SSP_ASSERT_NEVER(a_empty_result, clk_i, rst_ni, res_vld_o && res_o.item_kind == ssp_pkg::KindNone && !res_o.message_done, "Result without content.")
  `SSP_ASSERT_NEVER(a_status_no_done, clk_i, rst_ni, res_vld_o && !res_o.message_done && res_o.parse_status != ssp_pkg::StOk, "Status given before the final word.")
  `SSP_ASSERT_NEVER(a_seen_count, clk_i, rst_ni, pseen_q > pcount_q, "More points seen than the table holds.")

endmodule

[rtl/ssp_out_reg.sv]
// Result register of the parser: holds one result word until the sink takes it.
// Depends on ssp_pkg and ssp_stream_if.
module ssp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssp_pkg::result_t res_i,
  input  logic             load_i,
  output logic             free_o,
  ssp_stream_if.source     out_o
);

  logic             vld_q;
  ssp_pkg::result_t res_q;

  assign free_o        = !vld_q || out_o.ready;
  assign out_o.valid   = vld_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/shaping_snapshot_parser_unit.sv]
// Top level of the shaping snapshot parser: input register, parse core, result register.
// Depends on ssp_pkg, ssp_stream_if, ssp_in_reg, ssp_core and ssp_out_reg.
//
//   Channel  Dir  Word       Meaning
//   in_i     in   in_word_t  one message byte and its end-of-message flag
//   out_o    out  result_t   a completed field, and the status on the final byte
//
// One byte is accepted every cycle unless the result stalls; its word is captured in the result register.
// The rate is set by the single parse pass between the input and result registers.
// A byte that completes no field and is not the final one produces no word.
// Reset clears all parse state; the final byte of a message also returns it to reset.
// A stalled result holds the core, and the input register then holds one byte.
module shaping_snapshot_parser_unit #(
  parameter int unsigned MaxPoints = ssp_pkg::MaxPointsDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  ssp_stream_if.sink   in_i,
  ssp_stream_if.source out_o
);

  ssp_pkg::in_word_t word;
  ssp_pkg::result_t  res;
  logic              word_vld;
  logic              res_vld;
  logic              out_free;
  logic              adv;

  assign adv = word_vld && out_free;

  ssp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .word_o (word),
    .vld_o  (word_vld)
  );

  ssp_core #(
    .MaxPoints (MaxPoints)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_i    (word),
    .adv_i     (adv),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  ssp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .load_i (res_vld),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

[dv/tb_shaping_snapshot_parser_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the shaping snapshot parser, fed byte by byte over valid/ready.
// Needs ssp_pkg, ssp_stream_if and shaping_snapshot_parser_unit; predicts every result word.
module tb_shaping_snapshot_parser_unit;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned RandomBytes   = 1950;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  ssp_stream_if #(.payload_t(ssp_pkg::in_word_t)) in_if ();
  ssp_stream_if #(.payload_t(ssp_pkg::result_t))  out_if ();

  shaping_snapshot_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ssp_pkg::in_word_t feed_q[$];
  logic [7:0]        msg_bytes[$];
  ssp_pkg::result_t  expected_fields[$];
  int unsigned       total_words;
  int unsigned       in_accepted;
  int unsigned       n_errors;
  bit                tail_calm;

  ssp_pkg::phase_e ph;
  int unsigned     fld_n;
  logic [63:0]     fld_acc;
  logic [7:0]      id_left;
  logic            cur_dir;
  logic            cur_tab;
  int unsigned     pts_total;
  int unsigned     pts_done;
  logic [31:0]     bound_hold;
  logic [31:0]     bound_prev;
  logic [19:0]     prob_prev;
  logic            bad_msg;
  logic            bad_ver;

  function automatic void add_byte(logic [7:0] v);
    msg_bytes = {msg_bytes, v};
  endfunction

  function automatic void clear_parse();
    ph         = ssp_pkg::PhType;
    fld_n      = 0;
    fld_acc    = '0;
    id_left    = '0;
    cur_dir    = 1'b0;
    cur_tab    = 1'b0;
    pts_total  = 0;
    pts_done   = 0;
    bound_hold = '0;
    bound_prev = '0;
    prob_prev  = '0;
    bad_msg    = 1'b0;
    bad_ver    = 1'b0;
  endfunction

  function automatic bit shift_in(logic [7:0] b, int unsigned n);
    fld_acc = {fld_acc[55:0], b};
    fld_n++;
    if (fld_n >= n) begin
      fld_n = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic parse_snapshot_byte(ssp_pkg::in_word_t w);
    ssp_pkg::result_t r;
    ssp_pkg::phase_e  ph0;
    logic [31:0]      raw;
    logic [19:0]      p;
    logic [15:0]      cnt;
    bit               last;
    r   = '0;
    ph0 = ph;
    case (ph)
      ssp_pkg::PhType: begin
        if (w.data_byte != ssp_pkg::TypeByte) bad_msg = 1'b1;
        ph = ssp_pkg::PhVersion;
      end
      ssp_pkg::PhVersion: begin
        if (w.data_byte != ssp_pkg::VersionByte && !bad_msg) bad_ver = 1'b1;
        ph = ssp_pkg::PhIdLen;
      end
      ssp_pkg::PhIdLen: begin
        id_left = w.data_byte;
        fld_acc = '0;
        fld_n   = 0;
        ph      = (w.data_byte == 8'd0) ? ssp_pkg::PhRecCount : ssp_pkg::PhIdBytes;
      end
      ssp_pkg::PhIdBytes: begin
        r.item_kind   = ssp_pkg::KindId;
        r.field_value = {56'd0, w.data_byte};
        id_left--;
        if (id_left == 8'd0) ph = ssp_pkg::PhRecCount;
      end
      ssp_pkg::PhRecCount: begin
        if (shift_in(w.data_byte, 8)) begin
          r.item_kind      = ssp_pkg::KindCount;
          r.direction_slot = cur_dir;
          r.field_value    = fld_acc;
          fld_acc          = '0;
          cur_tab          = 1'b0;
          ph               = ssp_pkg::PhTabCount;
        end
      end
      ssp_pkg::PhTabCount: begin
        if (shift_in(w.data_byte, 2)) begin
          cnt     = fld_acc[15:0];
          fld_acc = '0;
          if (cnt == 16'd0 || cnt > ssp_pkg::MaxPointsDef) begin
            bad_msg = 1'b1;
            ph      = ssp_pkg::PhSink;
          end else begin
            pts_total  = 32'(cnt);
            pts_done   = 0;
            bound_prev = '0;
            prob_prev  = '0;
            ph         = ssp_pkg::PhBound;
          end
        end
      end
      ssp_pkg::PhBound: begin
        if (shift_in(w.data_byte, 4)) begin
          bound_hold = fld_acc[31:0];
          fld_acc    = '0;
          ph         = ssp_pkg::PhProb;
        end
      end
      ssp_pkg::PhProb: begin
        if (shift_in(w.data_byte, 4)) begin
          raw     = fld_acc[31:0];
          last    = (pts_done + 1 >= pts_total);
          fld_acc = '0;
          if (bound_hold == 32'd0 || raw > ssp_pkg::ProbOne) bad_msg = 1'b1;
          p = last ? ssp_pkg::ProbOne :
              ((raw > ssp_pkg::ProbOne) ? ssp_pkg::ProbOne : raw[19:0]);
          if (pts_done > 0 && bound_hold < bound_prev) bad_msg = 1'b1;
          if (p <= prob_prev) bad_msg = 1'b1;
          r.item_kind         = ssp_pkg::KindPoint;
          r.direction_slot    = cur_dir;
          r.table_select      = cur_tab;
          r.field_value       = {32'd0, bound_hold};
          r.point_probability = p;
          r.point_number      = pts_done[7:0];
          r.final_point       = last;
          bound_prev          = bound_hold;
          prob_prev           = p;
          pts_done++;
          if (!last) begin
            ph = ssp_pkg::PhBound;
          end else if (!cur_tab) begin
            cur_tab = 1'b1;
            ph      = ssp_pkg::PhTabCount;
          end else if (!cur_dir) begin
            cur_dir = 1'b1;
            cur_tab = 1'b0;
            ph      = ssp_pkg::PhRecCount;
          end else begin
            ph = ssp_pkg::PhTrail;
          end
        end
      end
      ssp_pkg::PhTrail: begin
        bad_msg = 1'b1;
      end
      default: ;
    endcase
    if (w.end_of_message) begin
      r.message_done = 1'b1;
      if (ph0 == ssp_pkg::PhType || ph0 == ssp_pkg::PhVersion) begin
        r.parse_status = ssp_pkg::StInvalid;
      end else if (bad_ver) begin
        r.parse_status = ssp_pkg::StVersion;
      end else if (bad_msg || ph != ssp_pkg::PhTrail) begin
        r.parse_status = ssp_pkg::StInvalid;
      end else begin
        r.parse_status = ssp_pkg::StOk;
      end
    end
    if (w.end_of_message || r.item_kind != ssp_pkg::KindNone) begin
      expected_fields = {expected_fields, r};
    end
    if (w.end_of_message) clear_parse();
  endtask

  task automatic put_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  task automatic put_table(int n, int emit_n, int err_at, int err_kind);
    logic [31:0] bnd;
    logic [31:0] prev_bnd;
    logic [31:0] b_out;
    logic [31:0] pr;
    logic [31:0] pr_before;
    logic [31:0] raw;
    bnd      = $urandom_range(1, 1000);
    prev_bnd = '0;
    pr       = '0;
    for (int i = 0; i < emit_n; i++) begin
      pr_before = pr;
      if (i > 0 && $urandom_range(0, 3) != 0) bnd = bnd + $urandom_range(1, 100000);
      if (i == n - 1 && $urandom_range(0, 7) == 0) bnd = 32'hFFFF_FFFF;
      if (i == n - 1) begin
        raw = ($urandom_range(0, 2) == 0) ? 32'(ssp_pkg::ProbOne) :
              $urandom_range(0, ssp_pkg::ProbOne);
      end else begin
        pr  = pr + $urandom_range(1, int'(ssp_pkg::ProbOne) / (n + 1));
        raw = pr;
      end
      b_out = bnd;
      if (i == err_at) begin
        case (err_kind)
          0: b_out = '0;
          1: b_out = (i > 0) ? prev_bnd - 1 : '0;
          2: raw = $urandom_range(int'(ssp_pkg::ProbOne) + 1, 32'hFFFF_FFFF);
          default: raw = (i == n - 1) ? 32'hFFFF_FFFF : pr_before;
        endcase
      end
      put_be(64'(b_out), 4);
      put_be(64'(raw), 4);
      prev_bnd = bnd;
    end
  endtask

  // Early messages walk through each kind of damage once; later ones draw it at random.
  task automatic build_message(int msg_no);
    int          mode;
    int          id_len;
    int          n;
    int          cut;
    int          bad_slot;
    int          slot;
    logic [7:0]  b;
    logic [15:0] cnt;
    logic [63:0] recs;
    msg_bytes.delete();
    mode = (msg_no < 9) ? msg_no : $urandom_range(0, 19);
    if (mode == 0) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    b = 8'($urandom_range(0, 255));
    if (b == ssp_pkg::TypeByte) b = ~b;
    add_byte((mode == 1) ? b : ssp_pkg::TypeByte);
    b = 8'($urandom_range(0, 255));
    if (b == ssp_pkg::VersionByte) b = ~b;
    add_byte((mode == 2 || (mode == 1 && b[0])) ? b : ssp_pkg::VersionByte);
    id_len = (msg_no == 9) ? 255 : $urandom_range(0, 4);
    add_byte(id_len[7:0]);
    repeat (id_len) add_byte(8'($urandom_range(0, 255)));
    bad_slot = $urandom_range(0, 3);
    slot     = 0;
    for (int d = 0; d < 2; d++) begin
      case ($urandom_range(0, 5))
        0: recs = '0;
        1: recs = '1;
        default: recs = {$urandom, $urandom};
      endcase
      put_be(recs, 8);
      for (int t = 0; t < 2; t++) begin
        n = $urandom_range(1, 4);
        if (mode == 4 && slot == bad_slot) begin
          put_be(64'(ssp_pkg::MaxPointsDef), 2);
          put_table(ssp_pkg::MaxPointsDef, $urandom_range(1, 3), -1, 0);
          return;
        end
        cnt = 16'(n);
        if (mode == 3 && slot == bad_slot) begin
          case ($urandom_range(0, 2))
            0: cnt = '0;
            1: cnt = '1;
            default: cnt = 16'($urandom_range(ssp_pkg::MaxPointsDef + 1, 16'hFFFF));
          endcase
        end
        put_be(64'(cnt), 2);
        put_table(n, n, ((mode == 7 || mode == 8) && slot == bad_slot) ?
                  $urandom_range(0, n - 1) : -1, $urandom_range(0, 3));
        slot++;
      end
    end
    if (mode == 5) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      msg_bytes = msg_bytes[0:cut-1];
    end
    if (mode == 6) repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic commit_message();
    ssp_pkg::in_word_t w;
    foreach (msg_bytes[i]) begin
      w.data_byte      = msg_bytes[i];
      w.end_of_message = (i == msg_bytes.size() - 1);
      feed_q = {feed_q, w};
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  int unsigned gap_left;
  int unsigned in_span;
  bit          in_no_gaps;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) in_accepted++;
      in_span++;
      if (in_span % 200 == 0) in_no_gaps = ($urandom_range(0, 2) == 0);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (feed_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!tail_calm && !in_no_gaps && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid   <= 1'b1;
          in_if.payload <= feed_q.pop_front();
        end
      end
      tail_calm <= (feed_q.size() < 200);
    end
  end

  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned taken_cnt;
  int unsigned out_span;
  bit          hold_done;
  bit          out_no_gaps;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) taken_cnt++;
      out_span++;
      if (out_span % 200 == 0) out_no_gaps = ($urandom_range(0, 2) == 0);
      if (!hold_done && taken_cnt >= 100) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!tail_calm && !out_no_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    ssp_pkg::result_t want;
    ssp_pkg::result_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (expected_fields.size() == 0) begin
          $display("%0t ns: result word with nothing expected, actual 0x%0h", $time, got);
          n_errors++;
        end else begin
          want = expected_fields.pop_front();
          check_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
          check_field("direction_slot", 64'(want.direction_slot), 64'(got.direction_slot));
          check_field("table_select", 64'(want.table_select), 64'(got.table_select));
          check_field("field_value", want.field_value, got.field_value);
          check_field("point_probability", 64'(want.point_probability),
                      64'(got.point_probability));
          check_field("point_number", 64'(want.point_number), 64'(got.point_number));
          check_field("final_point", 64'(want.final_point), 64'(got.final_point));
          check_field("message_done", 64'(want.message_done), 64'(got.message_done));
          check_field("parse_status", 64'(want.parse_status), 64'(got.parse_status));
        end
      end
      if (in_if.valid && in_if.ready) parse_snapshot_byte(in_if.payload);
    end
  end

  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t ns: no word moved for %0d cycles", $time, WatchdogLimit);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int msg_no;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    clear_parse();

    msg_bytes = '{ssp_pkg::TypeByte};
    commit_message();
    msg_bytes = '{ssp_pkg::TypeByte, ssp_pkg::VersionByte};
    commit_message();
    msg_bytes = '{8'hFF, 8'h00, 8'h00};
    commit_message();
    msg_bytes = '{ssp_pkg::TypeByte, 8'h80, 8'h00};
    commit_message();
    msg_bytes = '{ssp_pkg::TypeByte, ssp_pkg::VersionByte, 8'h00};
    commit_message();
    msg_bytes = '{ssp_pkg::TypeByte, ssp_pkg::VersionByte, 8'h02, 8'h00, 8'hFF};
    commit_message();

    msg_no = 0;
    while (feed_q.size() < RandomBytes) begin
      build_message(msg_no);
      commit_message();
      msg_no++;
    end
    total_words = feed_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (in_accepted != total_words) @(negedge clk_i);
    while (expected_fields.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (expected_fields.size() != 0) begin
      $display("%0t ns: %0d expected result words never arrived", $time, expected_fields.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
